FILE: rtl/core/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the SimCC keypoint decode unit
// Item formats, configuration layout, register indexes and queue sizes.
// ----------------------------------------------------------------------------
package scd_pkg;

	// Widths fixed by the item formats
	localparam int SCORE_W = 16;
	localparam int COORD_W = 16;
	localparam int JIDX_W  = 5;
	localparam int COEF_W  = 32;
	localparam int JCNT_W  = 6;
	// Halved bin index, enough for the largest supported row (4096 bins)
	localparam int POS_W   = 11;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT = 3'd6;

	// Register reset values
	localparam logic signed [COEF_W-1:0] COEF_ONE      = 32'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_ZERO     = 32'sd0;
	localparam logic [JCNT_W-1:0]        JOINT_CNT_RST = 6'd17;

	// Queue sizes
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

	// Parameter defaults
	localparam int MAX_BINS_DEF   = 512;
	localparam int MAX_JOINTS_DEF = 32;

	// Input item
	typedef struct packed {
		logic signed [SCORE_W-1:0] bin_score;
		logic                      axis;
		logic                      row_last;
	} bin_item_t;

	// Result item
	typedef struct packed {
		logic [JIDX_W-1:0]         joint_index;
		logic signed [COORD_W-1:0] image_x;
		logic signed [COORD_W-1:0] image_y;
		logic signed [SCORE_W-1:0] joint_score;
	} result_t;

	// Finished joint handed from the front to the back
	typedef struct packed {
		logic [JIDX_W-1:0]         joint_index;
		logic [POS_W-1:0]          px;
		logic [POS_W-1:0]          py;
		logic signed [SCORE_W-1:0] joint_score;
	} joint_rec_t;

	// Configuration registers
	typedef struct packed {
		logic signed [COEF_W-1:0] coef_xx;
		logic signed [COEF_W-1:0] coef_xy;
		logic signed [COEF_W-1:0] offset_x;
		logic signed [COEF_W-1:0] coef_yx;
		logic signed [COEF_W-1:0] coef_yy;
		logic signed [COEF_W-1:0] offset_y;
		logic [JCNT_W-1:0]        joint_count;
	} cfg_t;

endpackage

FILE: rtl/core/simcc_keypoint_decode_unit.sv
// ----------------------------------------------------------------------------
// simcc_keypoint_decode_unit: SimCC keypoint argmax decoder
// Streams bin scores per joint (x row, then y row), finds each row's peak
// and emits the affine-mapped joint position with its score.
// ----------------------------------------------------------------------------
// The unit takes one bin item per clock, back to back, as long as full is
// low; full rises only when four decoded joints are still waiting in the
// internal queue ahead of the transform pipeline. One result comes out per
// y row; the transform pipeline (two register stages of 32x12 multiplies
// and adds) also sustains one joint per clock while the result queue has
// room, so while results are popped the bin stream alone sets throughput.
// Results wait in a four-entry output queue until popped. The configuration
// registers may only be written while no joint is in flight.
// ----------------------------------------------------------------------------
module simcc_keypoint_decode_unit #(
	parameter int MAX_BINS   = scd_pkg::MAX_BINS_DEF,
	parameter int MAX_JOINTS = scd_pkg::MAX_JOINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  scd_pkg::bin_item_t                bin_item,
	output logic                              empty,
	input  logic                              pop,
	output scd_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import scd_pkg::*;

	localparam int MCW = $clog2(MID_DEPTH + 1);

	cfg_t              cfg_q;
	logic              take;
	logic              rec_push;
	joint_rec_t        rec_in;
	joint_rec_t        rec_out;
	logic              rec_empty;
	logic              rec_full;
	logic              rec_pop;
	logic [MCW-1:0]    rec_count;
	logic              out_push;
	result_t           out_item;
	logic              out_full;
	logic [OCNT_W-1:0] out_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx     <= COEF_ONE;
			cfg_q.coef_xy     <= COEF_ZERO;
			cfg_q.offset_x    <= COEF_ZERO;
			cfg_q.coef_yx     <= COEF_ZERO;
			cfg_q.coef_yy     <= COEF_ONE;
			cfg_q.offset_y    <= COEF_ZERO;
			cfg_q.joint_count <= JOINT_CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_XX:     cfg_q.coef_xx     <= cfg_data;
				REG_COEF_XY:     cfg_q.coef_xy     <= cfg_data;
				REG_OFFSET_X:    cfg_q.offset_x    <= cfg_data;
				REG_COEF_YX:     cfg_q.coef_yx     <= cfg_data;
				REG_COEF_YY:     cfg_q.coef_yy     <= cfg_data;
				REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data;
				REG_JOINT_COUNT: cfg_q.joint_count <= cfg_data[JCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full = rec_full;
	assign take = push && !rec_full;

	// front: argmax and joint assembly
	scd_front #(
		.MAX_BINS   (MAX_BINS),
		.MAX_JOINTS (MAX_JOINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (bin_item),
		.joint_count (cfg_q.joint_count),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	// queue between front and back
	scd_fifo #(
		.WIDTH ($bits(joint_rec_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_in),
		.rd_en   (rec_pop),
		.rd_data (rec_out),
		.empty   (rec_empty),
		.full    (rec_full),
		.count   (rec_count)
	);

	// back: affine transform
	scd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_empty (rec_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// result queue
	scd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty),
		.full    (out_full),
		.count   (out_count)
	);

	// occupancy of the middle queue and result queue full are status only
	logic unused_status;
	assign unused_status = out_full ^ (|rec_count);

endmodule

FILE: rtl/core/scd_fifo.sv
// ----------------------------------------------------------------------------
// scd_fifo: small register queue
// Flop-based first-in first-out queue with occupancy count.
// ----------------------------------------------------------------------------
module scd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/scd_front.sv
// ----------------------------------------------------------------------------
// scd_front: row argmax and joint assembly
// Tracks the running argmax of each bin row, holds the x result and emits
// a joint record when a y row ends.
// ----------------------------------------------------------------------------
module scd_front #(
	parameter int MAX_BINS   = scd_pkg::MAX_BINS_DEF,
	parameter int MAX_JOINTS = scd_pkg::MAX_JOINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  scd_pkg::bin_item_t                item,
	input  logic [scd_pkg::JCNT_W-1:0]        joint_count,
	output logic                              rec_push,
	output scd_pkg::joint_rec_t               rec
);
	import scd_pkg::*;

	localparam int BIW  = $clog2(MAX_BINS);
	localparam int CNTW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int LW   = 9;

	logic signed [SCORE_W-1:0] best_score_q;
	logic [BIW-1:0]            best_index_q;
	logic [BIW-1:0]            bin_pos_q;
	logic                      row_started_q;
	logic [POS_W-1:0]          held_x_pos_q;
	logic signed [SCORE_W-1:0] held_x_score_q;
	logic [CNTW-1:0]           joint_cnt_q;

	logic                      win;
	logic signed [SCORE_W-1:0] new_score;
	logic [BIW-1:0]            new_index;
	logic [BIW-1:0]            half_index;
	logic [BIW+POS_W-1:0]      half_ext;
	logic [POS_W-1:0]          half_pos;
	logic [LW-1:0]             limit;
	logic [CNTW+LW-1:0]        cnt_ext;
	logic [LW-1:0]             cnt_now;
	logic [LW-1:0]             cnt_inc;
	logic [LW-1:0]             cnt_next;
	logic                      y_end;

	// running argmax, first maximum wins
	assign win        = !row_started_q || (item.bin_score > best_score_q);
	assign new_score  = win ? item.bin_score : best_score_q;
	assign new_index  = win ? bin_pos_q : best_index_q;
	assign half_index = new_index >> 1;
	assign half_ext   = {{POS_W{1'b0}}, half_index};
	assign half_pos   = half_ext[POS_W-1:0];

	// joint counter wrap limit
	always_comb begin
		if (joint_count == '0 || {3'b000, joint_count} > LW'(MAX_JOINTS)) begin
			limit = LW'(MAX_JOINTS);
		end else begin
			limit = {3'b000, joint_count};
		end
	end

	assign cnt_ext  = {{LW{1'b0}}, joint_cnt_q};
	assign cnt_now  = cnt_ext[LW-1:0];
	assign cnt_inc  = cnt_now + 1'b1;
	assign cnt_next = (cnt_inc >= limit) ? '0 : cnt_inc;

	// record for the back end
	assign y_end                = take && item.row_last && item.axis;
	assign rec_push             = y_end;
	assign rec.joint_index      = cnt_now[JIDX_W-1:0];
	assign rec.px               = held_x_pos_q;
	assign rec.py               = half_pos;
	assign rec.joint_score      = (held_x_score_q > new_score) ? held_x_score_q : new_score;

	// row and joint state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q   <= '0;
			best_index_q   <= '0;
			bin_pos_q      <= '0;
			row_started_q  <= 1'b0;
			held_x_pos_q   <= '0;
			held_x_score_q <= '0;
			joint_cnt_q    <= '0;
		end else if (take) begin
			best_score_q <= new_score;
			best_index_q <= new_index;
			if (item.row_last) begin
				row_started_q <= 1'b0;
				bin_pos_q     <= '0;
				if (!item.axis) begin
					held_x_pos_q   <= half_pos;
					held_x_score_q <= new_score;
				end else begin
					joint_cnt_q <= cnt_next[CNTW-1:0];
				end
			end else begin
				row_started_q <= 1'b1;
				if (bin_pos_q != BIW'(MAX_BINS - 1)) begin
					bin_pos_q <= bin_pos_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/scd_back.sv
// ----------------------------------------------------------------------------
// scd_back: affine transform pipeline
// Multiplies the joint point by the 2x3 Q16.16 matrix, sums, scales down
// with truncation toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module scd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scd_pkg::cfg_t                 cfg,
	input  logic                          rec_empty,
	input  scd_pkg::joint_rec_t           rec,
	output logic                          rec_pop,
	input  logic [scd_pkg::OCNT_W-1:0]    out_count,
	output logic                          out_push,
	output scd_pkg::result_t              out_item
);
	import scd_pkg::*;

	localparam int PROD_W = COEF_W + POS_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = ACC_W - 16;

	logic                      v_s1;
	logic signed [PROD_W-1:0]  p_xx_s1;
	logic signed [PROD_W-1:0]  p_xy_s1;
	logic signed [PROD_W-1:0]  p_yx_s1;
	logic signed [PROD_W-1:0]  p_yy_s1;
	logic [JIDX_W-1:0]         jidx_s1;
	logic signed [SCORE_W-1:0] score_s1;

	logic                      v_s2;
	logic signed [ACC_W-1:0]   acc_x_s2;
	logic signed [ACC_W-1:0]   acc_y_s2;
	logic [JIDX_W-1:0]         jidx_s2;
	logic signed [SCORE_W-1:0] score_s2;

	logic [OCNT_W+1:0]         pending;
	logic signed [PROD_W-1:0]  px_s;
	logic signed [PROD_W-1:0]  py_s;

	// divide by 65536 toward zero, then clamp to 16 bits
	function automatic logic signed [COORD_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [Q_W-1:0] q;
		q = acc[ACC_W-1:16];
		if (acc[ACC_W-1] && (acc[15:0] != '0)) begin
			q = q + Q_W'(1);
		end
		if (q > Q_W'(32767)) begin
			scale_sat = 16'sh7fff;
		end else if (q < -Q_W'(32768)) begin
			scale_sat = 16'sh8000;
		end else begin
			scale_sat = q[COORD_W-1:0];
		end
	endfunction

	// issue only when the result queue has room for everything in flight
	assign pending = {2'b00, out_count} + {{(OCNT_W+1){1'b0}}, v_s1}
		+ {{(OCNT_W+1){1'b0}}, v_s2};
	assign rec_pop = !rec_empty && (pending < (OCNT_W+2)'(OUT_DEPTH));

	// point widened to the full product width, always non-negative
	assign px_s = PROD_W'(rec.px);
	assign py_s = PROD_W'(rec.py);

	// stage 1: products
	always_ff @(posedge clk) begin
		p_xx_s1  <= PROD_W'(cfg.coef_xx * px_s);
		p_xy_s1  <= PROD_W'(cfg.coef_xy * py_s);
		p_yx_s1  <= PROD_W'(cfg.coef_yx * px_s);
		p_yy_s1  <= PROD_W'(cfg.coef_yy * py_s);
		jidx_s1  <= rec.joint_index;
		score_s1 <= rec.joint_score;
	end

	// stage 2: sums with offsets
	always_ff @(posedge clk) begin
		acc_x_s2 <= ACC_W'(p_xx_s1) + ACC_W'(p_xy_s1) + ACC_W'(cfg.offset_x);
		acc_y_s2 <= ACC_W'(p_yx_s1) + ACC_W'(p_yy_s1) + ACC_W'(cfg.offset_y);
		jidx_s2  <= jidx_s1;
		score_s2 <= score_s1;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rec_pop;
			v_s2 <= v_s1;
		end
	end

	// result into the output queue
	assign out_push             = v_s2;
	assign out_item.joint_index = jidx_s2;
	assign out_item.image_x     = scale_sat(acc_x_s2);
	assign out_item.image_y     = scale_sat(acc_y_s2);
	assign out_item.joint_score = score_s2;

endmodule

FILE: tb/scd_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scd_decode_checker: result predictor and scoreboard for the keypoint decoder
// Follows the bin stream and register writes, predicts each decoded joint
// and compares every popped result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module scd_decode_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  scd_pkg::bin_item_t             bin_item,
	input  logic                           empty,
	input  logic                           pop,
	input  scd_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             joints_waiting,
	output int                             mismatch_count
);
	import scd_pkg::*;

	localparam int LAST_POS    = MAX_BINS_DEF - 1;
	localparam int JOINT_LIMIT = MAX_JOINTS_DEF;

	// Shadow copy of the transform and frame registers
	logic signed [COEF_W-1:0] sh_xx, sh_xy, sh_ox, sh_yx, sh_yy, sh_oy;
	logic [JCNT_W-1:0]        sh_joints;

	// Shadow of the row argmax and held x peak
	logic signed [SCORE_W-1:0] peak_score;
	logic signed [SCORE_W-1:0] held_score;
	int                        peak_pos;
	int                        bin_pos;
	int                        held_px;
	int                        joint_ctr;
	logic                      row_open;

	result_t joints_due[$];

	// Q16.16 affine row, truncated toward zero, saturated to 16 bits
	function automatic logic signed [COORD_W-1:0] map_coord(
		input logic signed [COEF_W-1:0] ka,
		input logic signed [COEF_W-1:0] kb,
		input logic signed [COEF_W-1:0] koff,
		input int                       px,
		input int                       py
	);
		longint acc;
		longint q;
		acc = longint'(ka) * px + longint'(kb) * py + longint'(koff);
		q = acc / 65536;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[COORD_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t                   due;
		result_t                   pred;
		logic signed [SCORE_W-1:0] top;
		int                        lim;
		int                        py;
		if (!arst_n) begin
			sh_xx          = COEF_ONE;
			sh_xy          = COEF_ZERO;
			sh_ox          = COEF_ZERO;
			sh_yx          = COEF_ZERO;
			sh_yy          = COEF_ONE;
			sh_oy          = COEF_ZERO;
			sh_joints      = JOINT_CNT_RST;
			peak_score     = '0;
			held_score     = '0;
			peak_pos       = 0;
			bin_pos        = 0;
			held_px        = 0;
			joint_ctr      = 0;
			row_open       = 1'b0;
			joints_due.delete();
			joints_waiting = 0;
			mismatch_count = 0;
		end else begin
			// Popped result against the oldest prediction
			if (pop && !empty) begin
				if (joints_due.size() == 0) begin
					$error("unexpected result: joint_index %0d image_x %0d image_y %0d score %0d",
						result.joint_index, result.image_x, result.image_y,
						result.joint_score);
					mismatch_count++;
				end else begin
					due = joints_due.pop_front();
					if (result.joint_index !== due.joint_index) begin
						$error("joint_index: expected %0d, got %0d",
							due.joint_index, result.joint_index);
						mismatch_count++;
					end
					if (result.image_x !== due.image_x) begin
						$error("image_x: expected %0d, got %0d", due.image_x, result.image_x);
						mismatch_count++;
					end
					if (result.image_y !== due.image_y) begin
						$error("image_y: expected %0d, got %0d", due.image_y, result.image_y);
						mismatch_count++;
					end
					if (result.joint_score !== due.joint_score) begin
						$error("joint_score: expected %0d, got %0d",
							due.joint_score, result.joint_score);
						mismatch_count++;
					end
				end
			end

			// Accepted bin: running argmax, first maximum wins
			if (push && !full) begin
				if (!row_open || bin_item.bin_score > peak_score) begin
					peak_score = bin_item.bin_score;
					peak_pos   = bin_pos;
				end
				row_open = 1'b1;
				if (bin_pos < LAST_POS)
					bin_pos++;
				if (bin_item.row_last) begin
					row_open = 1'b0;
					bin_pos  = 0;
					// the axis of the closing bin decides the row kind
					if (!bin_item.axis) begin
						held_px    = peak_pos / 2;
						held_score = peak_score;
					end else begin
						py  = peak_pos / 2;
						top = (held_score > peak_score) ? held_score : peak_score;
						pred.joint_index = joint_ctr[JIDX_W-1:0];
						pred.image_x     = map_coord(sh_xx, sh_xy, sh_ox, held_px, py);
						pred.image_y     = map_coord(sh_yx, sh_yy, sh_oy, held_px, py);
						pred.joint_score = top;
						joints_due.push_back(pred);
						// zero or oversized count means the full joint range
						lim = (sh_joints == 0 || sh_joints > JOINT_LIMIT) ? JOINT_LIMIT
							: int'(sh_joints);
						joint_ctr++;
						if (joint_ctr >= lim)
							joint_ctr = 0;
					end
				end
			end

			// Register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_COEF_XX:     sh_xx = cfg_data;
					REG_COEF_XY:     sh_xy = cfg_data;
					REG_OFFSET_X:    sh_ox = cfg_data;
					REG_COEF_YX:     sh_yx = cfg_data;
					REG_COEF_YY:     sh_yy = cfg_data;
					REG_OFFSET_Y:    sh_oy = cfg_data;
					REG_JOINT_COUNT: sh_joints = cfg_data[JCNT_W-1:0];
					default: ;
				endcase
			end

			joints_waiting = joints_due.size();
		end
	end

endmodule

FILE: tb/tb_simcc_keypoint_decode_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simcc_keypoint_decode_unit: stimulus and verdict for the keypoint decoder
// Directed rows for ties, extremes and odd row sequences, then phases of
// random joints under different register settings and idle patterns. The
// checker beside the block predicts and scores every decoded joint.
// ----------------------------------------------------------------------------
module tb_simcc_keypoint_decode_unit;
	import scd_pkg::*;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	localparam int PHASE_BINS  = 56;
	localparam int SETTLE_CYC  = 10;
	localparam int LONG_ROW    = 514;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	bin_item_t             bin_item  = '0;
	logic                  pop       = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  full;
	logic                  empty;
	result_t               result;

	int joints_waiting;
	int mismatch_count;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int bins_sent    = 0;

	simcc_keypoint_decode_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.bin_item  (bin_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scd_decode_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.bin_item       (bin_item),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.joints_waiting (joints_waiting),
		.mismatch_count (mismatch_count)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result side: random stalls
	always @(negedge clk)
		pop <= arst_n && ($urandom_range(99) >= rx_stall_pct);

	// Hard stop
	initial begin
		#(2_000_000);
		$display("** simcc_keypoint_decode_unit: FAILED **");
		$finish;
	end

	function automatic bin_item_t make_bin(input logic [SCORE_W-1:0] score,
		input logic ax, input logic last);
		bin_item_t it;
		it.bin_score = score;
		it.axis      = ax;
		it.row_last  = last;
		return it;
	endfunction

	// Score styles: full range, near ties, extremes, negative only
	function automatic logic [SCORE_W-1:0] pick_score(input int mode);
		logic [SCORE_W-1:0] v;
		case (mode)
			0: v = SCORE_W'($urandom_range(65535));
			1: v = SCORE_W'(int'($urandom_range(3)) - 1);
			2: begin
				case ($urandom_range(3))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
			default: v = 16'h8000 | SCORE_W'($urandom_range(32767));
		endcase
		return v;
	endfunction

	function automatic int row_len();
		return ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
	endfunction

	// Moderate coefficient (about +-4.0) and offset (about +-128.0)
	function automatic logic [COEF_W-1:0] mid_coef();
		return COEF_W'(int'($urandom_range(524288)) - 262144);
	endfunction

	function automatic logic [COEF_W-1:0] mid_offset();
		return COEF_W'(int'($urandom_range(16777216)) - 8388608);
	endfunction

	// One bin item; returns at a falling edge with push still high
	task automatic send_bin(input bin_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push     <= 1'b1;
		bin_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bins_sent++;
		@(negedge clk);
	endtask

	task automatic send_row(input logic ax, input int len, input int mode,
		input bit mix_axis);
		bin_item_t it;
		for (int k = 0; k < len; k++) begin
			it.bin_score = pick_score(mode);
			it.row_last  = (k == len - 1);
			it.axis      = (it.row_last || !mix_axis) ? ax : logic'($urandom_range(1));
			send_bin(it);
		end
	endtask

	// Clean joints mostly, then lone y rows, doubled x rows and mixed axes
	task automatic send_random_joint();
		int kind;
		int mode;
		kind = $urandom_range(99);
		mode = $urandom_range(3);
		if (kind < 80) begin
			send_row(AXIS_X, row_len(), mode, 0);
			send_row(AXIS_Y, row_len(), mode, 0);
		end else if (kind < 87) begin
			send_row(AXIS_Y, row_len(), mode, 0);
		end else if (kind < 93) begin
			send_row(AXIS_X, row_len(), mode, 0);
			send_row(AXIS_X, row_len(), $urandom_range(3), 0);
			send_row(AXIS_Y, row_len(), mode, 0);
		end else begin
			send_row(AXIS_X, row_len(), mode, 1);
			send_row(AXIS_Y, row_len(), mode, 1);
		end
	endtask

	// Hold the input until every predicted joint has been popped
	task automatic drain_results();
		push <= 1'b0;
		@(negedge clk);
		while (joints_waiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Write enable stays high across the burst
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [COEF_W-1:0] xx, input logic [COEF_W-1:0] xy,
		input logic [COEF_W-1:0] ox, input logic [COEF_W-1:0] yx,
		input logic [COEF_W-1:0] yy, input logic [COEF_W-1:0] oy,
		input logic [JCNT_W-1:0] jc);
		write_reg(REG_COEF_XX, xx);
		write_reg(REG_COEF_XY, xy);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_COEF_YX, yx);
		write_reg(REG_COEF_YY, yy);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_JOINT_COUNT, CFG_DATA_W'(jc));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int        start;
		int        nj;
		bin_item_t it;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// y row before any x row: held x is still the reset value
		send_bin(make_bin(16'd100, AXIS_Y, 1'b0));
		send_bin(make_bin(16'd100, AXIS_Y, 1'b0));
		send_bin(make_bin(-16'sd5, AXIS_Y, 1'b1));
		// x row with both score extremes, tie on the maximum
		send_bin(make_bin(16'h8000, AXIS_X, 1'b0));
		send_bin(make_bin(16'h7fff, AXIS_X, 1'b0));
		send_bin(make_bin(16'h7fff, AXIS_X, 1'b1));
		// second x row overwrites the held peak
		send_bin(make_bin(-16'sd1, AXIS_X, 1'b0));
		send_bin(make_bin(16'd5, AXIS_X, 1'b0));
		send_bin(make_bin(16'd7, AXIS_X, 1'b1));
		// axis flips mid row, closing bin says y
		send_bin(make_bin(16'h8000, AXIS_X, 1'b0));
		send_bin(make_bin(16'h8000, AXIS_Y, 1'b0));
		send_bin(make_bin(-16'sd2, AXIS_X, 1'b0));
		send_bin(make_bin(-16'sd3, AXIS_X, 1'b0));
		send_bin(make_bin(-16'sd2, AXIS_Y, 1'b1));
		// single-bin rows at the minimum score
		send_bin(make_bin(16'h8000, AXIS_X, 1'b1));
		send_bin(make_bin(16'h8000, AXIS_Y, 1'b1));
		// all-max x row, then a y row peaking at the maximum
		send_bin(make_bin(16'h7fff, AXIS_X, 1'b0));
		send_bin(make_bin(16'h7fff, AXIS_X, 1'b1));
		send_bin(make_bin(16'h0000, AXIS_Y, 1'b0));
		send_bin(make_bin(16'h7fff, AXIS_Y, 1'b0));
		send_bin(make_bin(16'hffff, AXIS_Y, 1'b1));
		// axis flips the other way, closing bin says x
		send_bin(make_bin(16'd5, AXIS_Y, 1'b0));
		send_bin(make_bin(16'd9, AXIS_Y, 1'b0));
		send_bin(make_bin(16'd3, AXIS_X, 1'b1));

		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase)
				0: load_config(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE,
					COEF_ZERO, JOINT_CNT_RST);
				1: load_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
					32'h80000000, 32'h80000000, 6'd32);
				2: load_config(mid_coef(), mid_coef(), mid_offset(), mid_coef(),
					mid_coef(), mid_offset(), 6'd1);
				3: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, 6'd0);
				4: load_config(mid_coef(), mid_coef(), mid_offset(), mid_coef(),
					mid_coef(), mid_offset(), 6'd63);
				5: load_config(mid_coef(), mid_coef(), mid_offset(), mid_coef(),
					mid_coef(), mid_offset(), 6'd3);
				6: load_config(COEF_ZERO, COEF_ZERO, 32'h7fffffff, COEF_ZERO, COEF_ZERO,
					32'h80000000, JCNT_W'($urandom_range(1, 32)));
				default: load_config(mid_coef(), mid_coef(), mid_offset(), mid_coef(),
					mid_coef(), mid_offset(), JCNT_W'($urandom_range(63)));
			endcase

			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
				default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase

			// Row longer than the bin range: winners past the end land on the last index
			if (phase == 0) begin
				for (int k = 0; k < LONG_ROW; k++) begin
					if (k < LONG_ROW - 5)
						it.bin_score = SCORE_W'(int'($urandom_range(31768)) - 32768);
					else
						it.bin_score = SCORE_W'(k);
					it.axis     = AXIS_X;
					it.row_last = (k == LONG_ROW - 1);
					send_bin(it);
				end
				send_row(AXIS_Y, row_len(), 0, 0);
			end

			start = bins_sent;
			nj    = 0;
			while (bins_sent - start < PHASE_BINS) begin
				if ((phase == 2 && nj == 3) || $urandom_range(39) == 0)
					drain_results();
				send_random_joint();
				nj++;
			end
		end

		push <= 1'b0;
		@(negedge clk);
		while (joints_waiting != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatch_count == 0 && joints_waiting == 0)
			$display("** simcc_keypoint_decode_unit: PASSED **");
		else
			$display("** simcc_keypoint_decode_unit: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/scd_pkg.sv
rtl/core/scd_fifo.sv
rtl/core/scd_front.sv
rtl/core/scd_back.sv
rtl/core/simcc_keypoint_decode_unit.sv
tb/scd_decode_checker.sv
tb/tb_simcc_keypoint_decode_unit.sv
